FILE: design/line_overlay_pixel_shade_macros.svh
// assertion helpers used by lops_div_step
`ifndef LINE_OVERLAY_PIXEL_SHADE_MACROS_SVH
`define LINE_OVERLAY_PIXEL_SHADE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define LOPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LOPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lops_pkg.sv
package lops_pkg;

    localparam int LOPS_MAX_COLUMNS = 4096;
    localparam int LOPS_MAX_ROWS    = 4096;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_LINE_CENTER     = 3'd0,
        REG_HALF_WIDTH      = 3'd1,
        REG_ROW_START       = 3'd2,
        REG_ROW_END         = 3'd3,
        REG_LINE_KIND       = 3'd4,
        REG_DARKEN_PERCENT  = 3'd5,
        REG_LIGHTEN_PERCENT = 3'd6,
        REG_FULL_SWING      = 3'd7
    } lops_reg_t;

    typedef enum logic [1:0] {
        KIND_DARK  = 2'd0,
        KIND_LIGHT = 2'd1,
        KIND_TINT  = 2'd2
    } lops_kind_t;

    localparam logic [7:0] LUMA_LO_LIMITED   = 8'd16;
    localparam logic [7:0] LUMA_HI_LIMITED   = 8'd235;
    localparam logic [7:0] CHROMA_HI_LIMITED = 8'd240;
    localparam logic [7:0] FULL_HI           = 8'd255;
    localparam logic [7:0] PERCENT_SCALE     = 8'd100;

    localparam logic signed [8:0] DARKEN_RESET  = 9'sd40;
    localparam logic signed [8:0] LIGHTEN_RESET = 9'sd40;

    typedef struct packed {
        logic signed [13:0] line_center;
        logic [7:0]         half_width;
        logic [11:0]        row_start;
        logic [12:0]        row_end;
        logic [1:0]         line_kind;
        logic signed [8:0]  darken_percent;
        logic signed [8:0]  lighten_percent;
        logic               full_swing;
    } lops_cfg_t;

    // item as it moves through the quotient stages
    typedef struct packed {
        logic [7:0]  luma;
        logic [7:0]  chroma;
        logic        shade;
        logic        tint;
        logic        below;
        logic        above;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [14:0] den;
        logic [22:0] rem;
        logic [7:0]  quo;
    } lops_div_t;

endpackage

FILE: design/lops_regs.sv
module lops_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lops_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lops_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lops_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output lops_pkg::lops_cfg_t                cfg
);
    import lops_pkg::*;

    lops_cfg_t cfg_reg;
    lops_cfg_t cfg_next;
    lops_reg_t idx;
    logic      wr_en;

    assign idx    = lops_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_LINE_CENTER:     cfg_next.line_center     = $signed(pwdata[13:0]);
                REG_HALF_WIDTH:      cfg_next.half_width      = pwdata[7:0];
                REG_ROW_START:       cfg_next.row_start       = pwdata[11:0];
                REG_ROW_END:         cfg_next.row_end         = pwdata[12:0];
                REG_LINE_KIND:       cfg_next.line_kind       = pwdata[1:0];
                REG_DARKEN_PERCENT:  cfg_next.darken_percent  = $signed(pwdata[8:0]);
                REG_LIGHTEN_PERCENT: cfg_next.lighten_percent = $signed(pwdata[8:0]);
                REG_FULL_SWING:      cfg_next.full_swing      = pwdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LINE_CENTER:     prdata = CFG_DATA_W'(cfg_reg.line_center);
            REG_HALF_WIDTH:      prdata = CFG_DATA_W'(cfg_reg.half_width);
            REG_ROW_START:       prdata = CFG_DATA_W'(cfg_reg.row_start);
            REG_ROW_END:         prdata = CFG_DATA_W'(cfg_reg.row_end);
            REG_LINE_KIND:       prdata = CFG_DATA_W'(cfg_reg.line_kind);
            REG_DARKEN_PERCENT:  prdata = CFG_DATA_W'(cfg_reg.darken_percent);
            REG_LIGHTEN_PERCENT: prdata = CFG_DATA_W'(cfg_reg.lighten_percent);
            REG_FULL_SWING:      prdata = CFG_DATA_W'(cfg_reg.full_swing);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_center     <= '0;
            cfg_reg.half_width      <= '0;
            cfg_reg.row_start       <= '0;
            cfg_reg.row_end         <= '0;
            cfg_reg.line_kind       <= '0;
            cfg_reg.darken_percent  <= DARKEN_RESET;
            cfg_reg.lighten_percent <= LIGHTEN_RESET;
            cfg_reg.full_swing      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/lops_front.sv
module lops_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lops_pkg::lops_cfg_t  cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [11:0]          column,
    input  logic [11:0]          row,
    input  logic [7:0]           luma_in,
    input  logic [7:0]           chroma_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lops_pkg::lops_div_t  out_data
);
    import lops_pkg::*;

    typedef struct packed {
        logic [7:0]        luma;
        logic [7:0]        chroma;
        logic              shade;
        logic              tint;
        logic [7:0]        v;
        logic [7:0]        m;
        logic [7:0]        wn;
        logic signed [9:0] s;
        logic [7:0]        lo;
        logic [7:0]        hi;
        logic [14:0]       den;
    } s1_t;

    typedef struct packed {
        logic [7:0]        luma;
        logic [7:0]        chroma;
        logic              shade;
        logic              tint;
        logic [15:0]       p1;
        logic signed [9:0] s;
        logic [22:0]       vden;
        logic [22:0]       loden;
        logic [22:0]       hiden;
        logic [7:0]        lo;
        logic [7:0]        hi;
        logic [14:0]       den;
    } s2_t;

    typedef struct packed {
        logic [7:0]         luma;
        logic [7:0]         chroma;
        logic               shade;
        logic               tint;
        logic signed [26:0] t;
        logic [22:0]        vden;
        logic [22:0]        loden;
        logic [22:0]        hiden;
        logic [7:0]         lo;
        logic [7:0]         hi;
        logic [14:0]        den;
    } s3_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;
    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    s3_t       s3_reg, s3_next;
    lops_div_t s4_reg, s4_next;

    logic signed [14:0] off;
    logic signed [14:0] hw_s;
    logic [14:0]        off_abs;
    logic [7:0]         a8;
    logic               in_cols;
    logic               in_rows;
    logic               col_ok;
    logic               in_streak;
    lops_kind_t         kind;
    logic               kind_ok;
    logic signed [26:0] num;

    assign r4       = !v4_reg || out_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    // stage 1: streak test, weight and operand selection
    assign off     = $signed({3'b000, column}) - $signed({cfg.line_center[13], cfg.line_center});
    assign hw_s    = $signed({7'b0000000, cfg.half_width});
    assign off_abs = off[14] ? 15'(-off) : 15'(off);
    assign a8      = off_abs[7:0];
    assign in_cols = (off >= -hw_s) && (off < hw_s);
    assign in_rows = ({1'b0, row} >= {1'b0, cfg.row_start}) && ({1'b0, row} < cfg.row_end)
                     && (int'(row) < LOPS_MAX_ROWS);
    assign col_ok  = (column != 12'd0) && (int'(column) < LOPS_MAX_COLUMNS);
    assign in_streak = (cfg.half_width != 8'd0) && in_cols && in_rows && col_ok;
    assign kind    = lops_kind_t'(cfg.line_kind);

    always_comb
    begin
        s1_next        = '0;
        s1_next.luma   = luma_in;
        s1_next.chroma = chroma_in;
        s1_next.wn     = cfg.half_width - a8;
        s1_next.den    = 15'(cfg.half_width) * 15'(PERCENT_SCALE);
        s1_next.lo     = cfg.full_swing ? 8'd0 : LUMA_LO_LIMITED;
        s1_next.hi     = cfg.full_swing ? FULL_HI : LUMA_HI_LIMITED;
        kind_ok        = 1'b1;
        unique case (kind)
            KIND_DARK:
            begin
                s1_next.v = luma_in;
                s1_next.m = luma_in;
                s1_next.s = -10'(cfg.darken_percent);
            end
            KIND_LIGHT:
            begin
                s1_next.v = luma_in;
                s1_next.m = FULL_HI - luma_in;
                s1_next.s = 10'(cfg.lighten_percent);
            end
            KIND_TINT:
            begin
                s1_next.tint = 1'b1;
                s1_next.v    = chroma_in;
                s1_next.m    = chroma_in;
                s1_next.s    = -10'(cfg.lighten_percent);
                s1_next.hi   = cfg.full_swing ? FULL_HI : CHROMA_HI_LIMITED;
            end
            default:
            begin
                kind_ok = 1'b0;
            end
        endcase
        s1_next.shade = in_streak && kind_ok;
    end

    // stage 2: weight product and scaled bounds
    always_comb
    begin
        s2_next.luma   = s1_reg.luma;
        s2_next.chroma = s1_reg.chroma;
        s2_next.shade  = s1_reg.shade;
        s2_next.tint   = s1_reg.tint;
        s2_next.p1     = 16'(s1_reg.m) * 16'(s1_reg.wn);
        s2_next.s      = s1_reg.s;
        s2_next.vden   = 23'(s1_reg.v) * 23'(s1_reg.den);
        s2_next.hiden  = 23'(s1_reg.hi) * 23'(s1_reg.den);
        s2_next.loden  = (s1_reg.lo != 8'd0) ? 23'({s1_reg.den, 4'b0000}) : 23'd0;
        s2_next.lo     = s1_reg.lo;
        s2_next.hi     = s1_reg.hi;
        s2_next.den    = s1_reg.den;
    end

    // stage 3: strength product
    always_comb
    begin
        s3_next.luma   = s2_reg.luma;
        s3_next.chroma = s2_reg.chroma;
        s3_next.shade  = s2_reg.shade;
        s3_next.tint   = s2_reg.tint;
        s3_next.t      = 27'($signed({1'b0, s2_reg.p1})) * 27'(s2_reg.s);
        s3_next.vden   = s2_reg.vden;
        s3_next.loden  = s2_reg.loden;
        s3_next.hiden  = s2_reg.hiden;
        s3_next.lo     = s2_reg.lo;
        s3_next.hi     = s2_reg.hi;
        s3_next.den    = s2_reg.den;
    end

    // stage 4: numerator and clamp decision
    assign num = $signed({4'b0000, s3_reg.vden}) + s3_reg.t;

    always_comb
    begin
        s4_next.luma   = s3_reg.luma;
        s4_next.chroma = s3_reg.chroma;
        s4_next.shade  = s3_reg.shade;
        s4_next.tint   = s3_reg.tint;
        s4_next.below  = num < $signed({4'b0000, s3_reg.loden});
        s4_next.above  = num > $signed({4'b0000, s3_reg.hiden});
        s4_next.lo     = s3_reg.lo;
        s4_next.hi     = s3_reg.hi;
        s4_next.den    = s3_reg.den;
        s4_next.rem    = num[22:0];
        s4_next.quo    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
            if (r4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            s1_reg <= s1_next;
        end
        if (r2)
        begin
            s2_reg <= s2_next;
        end
        if (r3)
        begin
            s3_reg <= s3_next;
        end
        if (r4)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

endmodule

FILE: design/lops_div_step.sv
`include "line_overlay_pixel_shade_macros.svh"

module lops_div_step #(
    parameter int BIT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lops_pkg::lops_div_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lops_pkg::lops_div_t  out_data
);
    import lops_pkg::*;

    logic       valid_reg;
    lops_div_t  data_reg;
    lops_div_t  data_next;
    logic [22:0] dshift;
    logic [22:0] dshift_out;
    logic [7:0]  low_mask;

    assign dshift   = {8'd0, in_data.den} << BIT;
    assign in_ready = !valid_reg || out_ready;

    // one restoring quotient bit
    always_comb
    begin
        data_next = in_data;
        if (in_data.rem >= dshift)
        begin
            data_next.rem      = in_data.rem - dshift;
            data_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign dshift_out = {8'd0, data_reg.den} << BIT;
    assign low_mask   = (8'd1 << BIT) - 8'd1;

    `LOPS_ASSERT_IMPL(a_rem_range,
        valid_reg && data_reg.shade && !data_reg.below && !data_reg.above,
        data_reg.rem < dshift_out, "remainder out of range after quotient step")
    `LOPS_ASSERT_IMPL(a_low_bits_clear, valid_reg,
        (data_reg.quo & low_mask) == 8'd0, "quotient bit set ahead of its stage")
    `LOPS_ASSERT_IMPL(a_clamp_exclusive, valid_reg,
        !(data_reg.below && data_reg.above), "both clamp flags set")

endmodule

FILE: design/line_overlay_pixel_shade.sv
// Vertical streak shader for packed 4:2:2 pixels. A pixel transfer taken on s_tdata
// passes to m_tdata through twelve register stages (four stages for the streak test,
// the weight and strength products and the clamp decision, then eight stages of a
// restoring divider that settles one quotient bit each); while the output is not
// stalled the sustained rate is one pixel per clock. Each stage holds its own valid
// bit, so bubbles close up while the output is stalled. Pixels outside the streak,
// or with line_kind 3, pass through unchanged. Registers sit on the APB port at byte
// addresses 0x00..0x1C in the order line_center, half_width, row_start, row_end,
// line_kind, darken_percent, lighten_percent, full_swing. The user must see that they
// are written only while no pixel is in flight; the block itself has no check for it.
module line_overlay_pixel_shade (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lops_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lops_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lops_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [39:0]                        s_tdata,  // column, row, luma_in, chroma_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata   // luma_out, chroma_out
);
    import lops_pkg::*;

    localparam int DIV_STEPS = 8;

    lops_cfg_t  cfg;
    logic       stg_valid [DIV_STEPS+1];
    logic       stg_ready [DIV_STEPS+1];
    lops_div_t  stg_data  [DIV_STEPS+1];
    lops_div_t  last;
    logic [7:0] res;

    lops_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lops_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .column    (s_tdata[11:0]),
        .row       (s_tdata[23:12]),
        .luma_in   (s_tdata[31:24]),
        .chroma_in (s_tdata[39:32]),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        lops_div_step #(
            .BIT (DIV_STEPS - 1 - i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    assign stg_ready[DIV_STEPS] = m_tready;
    assign m_tvalid             = stg_valid[DIV_STEPS];
    assign last                 = stg_data[DIV_STEPS];

    // clamp to the legal range, else the truncated quotient
    always_comb
    begin
        priority if (last.below)
        begin
            res = last.lo;
        end
        else if (last.above)
        begin
            res = last.hi;
        end
        else
        begin
            res = last.quo;
        end
    end

    assign m_tdata[7:0]  = (last.shade && !last.tint) ? res : last.luma;
    assign m_tdata[15:8] = (last.shade && last.tint) ? res : last.chroma;

endmodule

FILE: test/tb_line_overlay_pixel_shade.sv
`timescale 1ns / 1ps

module tb_line_overlay_pixel_shade;

    import lops_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]  chroma;
        logic [7:0]  luma;
        logic [11:0] row;
        logic [11:0] column;
    } pixel_t;

    typedef struct packed {
        logic [7:0] chroma;
        logic [7:0] luma;
    } shade_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [39:0]           s_tdata;   // column, row, luma_in, chroma_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;   // luma_out, chroma_out

    lops_cfg_t stream_cfg;
    shade_t    shaded_q[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    line_overlay_pixel_shade dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [7:0] clamp_quotient(longint num, longint den, longint lo,
                                                  longint hi);
        if (num < lo * den)
            return 8'(lo);
        if (num > hi * den)
            return 8'(hi);
        return 8'(num / den);
    endfunction

    function automatic shade_t shade_pixel(pixel_t p, lops_cfg_t c);
        shade_t res;
        longint hw;
        longint off;
        longint wn;
        longint den;
        longint lo;
        longint hi_l;
        longint hi_c;
        longint y;
        longint ch;
        res.luma   = p.luma;
        res.chroma = p.chroma;
        hw  = longint'(c.half_width);
        off = longint'(p.column) - longint'($signed(c.line_center));
        y   = longint'(p.luma);
        ch  = longint'(p.chroma);
        if (hw != 0 && p.row >= c.row_start && {1'b0, p.row} < c.row_end
            && off >= -hw && off < hw && p.column != 12'd0)
        begin
            wn   = hw - (off < 0 ? -off : off);
            den  = longint'(PERCENT_SCALE) * hw;
            lo   = c.full_swing ? 0 : longint'(LUMA_LO_LIMITED);
            hi_l = c.full_swing ? longint'(FULL_HI) : longint'(LUMA_HI_LIMITED);
            hi_c = c.full_swing ? longint'(FULL_HI) : longint'(CHROMA_HI_LIMITED);
            case (c.line_kind)
                KIND_DARK:
                    res.luma = clamp_quotient(
                        y * den - y * wn * longint'($signed(c.darken_percent)), den, lo, hi_l);
                KIND_LIGHT:
                    res.luma = clamp_quotient(
                        y * den + (255 - y) * wn * longint'($signed(c.lighten_percent)),
                        den, lo, hi_l);
                KIND_TINT:
                    res.chroma = clamp_quotient(
                        ch * den - ch * wn * longint'($signed(c.lighten_percent)),
                        den, lo, hi_c);
                default:
                    ;
            endcase
        end
        return res;
    endfunction

    function automatic pixel_t make_pixel(int col, int row, int y, int ch);
        pixel_t p;
        p.column = 12'(col);
        p.row    = 12'(row);
        p.luma   = 8'(y);
        p.chroma = 8'(ch);
        return p;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        shade_t got;
        shade_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (shaded_q.size() == 0)
                flag_mismatch($sformatf("unexpected transfer %h", got));
            else
            begin
                want = shaded_q.pop_front();
                if (got.luma !== want.luma)
                    flag_mismatch($sformatf("luma_out %0d, want %0d", got.luma, want.luma));
                if (got.chroma !== want.chroma)
                    flag_mismatch($sformatf("chroma_out %0d, want %0d",
                                            got.chroma, want.chroma));
            end
        end
    end

    always @(negedge clk)
        m_tready = (recv_stall_pct == 0) || (int'($urandom_range(99)) >= recv_stall_pct);

    task automatic send_pixel(pixel_t p);
        while (send_idle_pct > 0 && int'($urandom_range(99)) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        shaded_q.push_back(shade_pixel(p, stream_cfg));
        @(negedge clk);
    endtask

    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (shaded_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(lops_reg_t r, logic [31:0] v);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {r, 2'b00};
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (r)
            REG_LINE_CENTER:     stream_cfg.line_center     = v[13:0];
            REG_HALF_WIDTH:      stream_cfg.half_width      = v[7:0];
            REG_ROW_START:       stream_cfg.row_start       = v[11:0];
            REG_ROW_END:         stream_cfg.row_end         = v[12:0];
            REG_LINE_KIND:       stream_cfg.line_kind       = v[1:0];
            REG_DARKEN_PERCENT:  stream_cfg.darken_percent  = v[8:0];
            REG_LIGHTEN_PERCENT: stream_cfg.lighten_percent = v[8:0];
            REG_FULL_SWING:      stream_cfg.full_swing      = v[0];
            default:             ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic verify_regs();
        lops_reg_t        r;
        logic [31:0]      val;
        bit               ok;
        for (int i = 0; i < 8; i++)
        begin
            r       = lops_reg_t'(i);
            psel    = 1'b1;
            pwrite  = 1'b0;
            penable = 1'b0;
            paddr   = {r, 2'b00};
            @(negedge clk);
            penable = 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            val = prdata;
            @(negedge clk);
            psel    = 1'b0;
            penable = 1'b0;
            case (r)
                REG_LINE_CENTER:     ok = val[13:0] === stream_cfg.line_center;
                REG_HALF_WIDTH:      ok = val[7:0]  === stream_cfg.half_width;
                REG_ROW_START:       ok = val[11:0] === stream_cfg.row_start;
                REG_ROW_END:         ok = val[12:0] === stream_cfg.row_end;
                REG_LINE_KIND:       ok = val[1:0]  === stream_cfg.line_kind;
                REG_DARKEN_PERCENT:  ok = val[8:0]  === stream_cfg.darken_percent;
                REG_LIGHTEN_PERCENT: ok = val[8:0]  === stream_cfg.lighten_percent;
                default:             ok = val[0]    === stream_cfg.full_swing;
            endcase
            if (!ok)
                flag_mismatch($sformatf("register %s reads %h", r.name(), val));
        end
    endtask

    task automatic set_streak(int center, int hw, int rs, int re);
        write_reg(REG_LINE_CENTER, center);
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_ROW_START, rs);
        write_reg(REG_ROW_END, re);
    endtask

    task automatic test_reset_passthrough();
        send_pixel(make_pixel(0, 0, 0, 0));
        send_pixel(make_pixel(4095, 4095, 255, 255));
        send_pixel(make_pixel(1, 1, 128, 128));
    endtask

    task automatic test_register_access();
        wait_drain();
        verify_regs();
        set_streak(100, 8, 10, 20);
        write_reg(REG_LINE_KIND, KIND_DARK);
        write_reg(REG_DARKEN_PERCENT, 255);
        write_reg(REG_LIGHTEN_PERCENT, -255);
        write_reg(REG_FULL_SWING, 0);
        verify_regs();
    endtask

    task automatic test_dark_streak();
        // zero weight at the left edge, still clamped
        send_pixel(make_pixel(92, 15, 0, 100));
        send_pixel(make_pixel(99, 15, 200, 77));
        send_pixel(make_pixel(100, 10, 255, 9));
        send_pixel(make_pixel(107, 19, 120, 0));
        send_pixel(make_pixel(108, 15, 120, 0));
        send_pixel(make_pixel(100, 9, 120, 0));
        send_pixel(make_pixel(100, 20, 120, 0));
    endtask

    task automatic test_light_and_tint();
        wait_drain();
        write_reg(REG_LINE_KIND, KIND_LIGHT);
        send_pixel(make_pixel(100, 15, 200, 50));
        wait_drain();
        write_reg(REG_LIGHTEN_PERCENT, 255);
        write_reg(REG_FULL_SWING, 1);
        send_pixel(make_pixel(104, 12, 100, 50));
        wait_drain();
        write_reg(REG_LINE_KIND, KIND_TINT);
        write_reg(REG_LIGHTEN_PERCENT, 40);
        send_pixel(make_pixel(103, 15, 30, 250));
        wait_drain();
        write_reg(REG_FULL_SWING, 0);
        send_pixel(make_pixel(100, 15, 30, 255));
        send_pixel(make_pixel(92, 15, 30, 250));
        wait_drain();
        write_reg(REG_LINE_KIND, KIND_UNUSED);
        send_pixel(make_pixel(100, 15, 30, 250));
    endtask

    task automatic test_column_zero();
        wait_drain();
        set_streak(0, 5, 0, 4096);
        write_reg(REG_LINE_KIND, KIND_DARK);
        write_reg(REG_DARKEN_PERCENT, 100);
        send_pixel(make_pixel(0, 0, 200, 200));
        send_pixel(make_pixel(1, 4095, 200, 200));
        send_pixel(make_pixel(4, 100, 255, 0));
    endtask

    task automatic test_row_and_center_limits();
        wait_drain();
        set_streak(100, 8, 50, 50);
        send_pixel(make_pixel(100, 50, 200, 200));
        wait_drain();
        set_streak(100, 8, 4095, 4096);
        send_pixel(make_pixel(100, 4095, 200, 200));
        wait_drain();
        set_streak(-64, 255, 0, 4096);
        send_pixel(make_pixel(190, 4095, 180, 60));
        wait_drain();
        set_streak(4159, 255, 0, 4096);
        send_pixel(make_pixel(4095, 0, 180, 60));
    endtask

    task automatic pick_streak(bit edge_case);
        int center;
        int hw;
        int rs;
        int re;
        int kind;
        if (edge_case)
        begin
            case ($urandom_range(3))
                0:       center = -64;
                1:       center = 4159;
                2:       center = 0;
                default: center = 4095;
            endcase
            hw   = $urandom_range(1) ? 255 : 1;
            rs   = $urandom_range(1) ? 0 : 4095;
            re   = 4096;
            kind = $urandom_range(2);
            write_reg(REG_DARKEN_PERCENT, $urandom_range(1) ? 255 : -255);
            write_reg(REG_LIGHTEN_PERCENT, $urandom_range(1) ? 255 : -255);
        end
        else
        begin
            center = int'($urandom_range(4223)) - 64;
            hw     = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1, 24);
            rs     = $urandom_range(4095);
            if ($urandom_range(3) == 0)
                re = $urandom_range(4096);
            else
                re = rs + 1 + int'($urandom_range(300));
            if (re > 4096)
                re = 4096;
            kind = ($urandom_range(9) == 0) ? KIND_UNUSED : $urandom_range(2);
            write_reg(REG_DARKEN_PERCENT, int'($urandom_range(510)) - 255);
            write_reg(REG_LIGHTEN_PERCENT, int'($urandom_range(510)) - 255);
        end
        set_streak(center, hw, rs, re);
        write_reg(REG_LINE_KIND, kind);
        write_reg(REG_FULL_SWING, $urandom_range(1));
    endtask

    task automatic send_random_pixel();
        int col;
        int row;
        int span;
        if ($urandom_range(99) < 80)
        begin
            span = int'(stream_cfg.half_width) + 2;
            col  = int'($signed(stream_cfg.line_center)) + int'($urandom_range(2 * span)) - span;
            if (col < 0)
                col = 0;
            if (col > 4095)
                col = 4095;
            if (stream_cfg.row_end > {1'b0, stream_cfg.row_start})
                row = $urandom_range(int'(stream_cfg.row_start), int'(stream_cfg.row_end) - 1);
            else
                row = $urandom_range(4095);
        end
        else
        begin
            col = $urandom_range(4095);
            row = $urandom_range(4095);
        end
        send_pixel(make_pixel(col, row, $urandom_range(255), $urandom_range(255)));
    endtask

    task automatic test_random_streaks(int send_pct, int recv_pct, bit pause_once);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int k = 0; k < 7; k++)
        begin
            wait_drain();
            pick_streak(k == 0);
            for (int i = 0; i < 62; i++)
            begin
                // hold the sender until the pipeline is empty
                if (pause_once && k == 1 && i == 31)
                    wait_drain();
                send_random_pixel();
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        stream_cfg = '{line_center: '0, half_width: '0, row_start: '0, row_end: '0,
                       line_kind: KIND_DARK, darken_percent: DARKEN_RESET,
                       lighten_percent: LIGHTEN_RESET, full_swing: 1'b0};
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_passthrough();
        test_register_access();
        test_dark_streak();
        test_light_and_tint();
        test_column_zero();
        test_row_and_center_limits();
        test_random_streaks(0, 0, 1'b0);
        test_random_streaks(53, 0, 1'b1);
        test_random_streaks(0, 53, 1'b0);
        test_random_streaks(17, 17, 1'b0);

        wait_drain();
        repeat (24)
            @(posedge clk);
        if (shaded_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", shaded_q.size()));
        if (mismatch_count == 0)
            $display("line_overlay_pixel_shade verification clean");
        else
            $display("line_overlay_pixel_shade verification failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("line_overlay_pixel_shade verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/lops_pkg.sv
design/lops_regs.sv
design/lops_front.sv
design/lops_div_step.sv
design/line_overlay_pixel_shade.sv
test/tb_line_overlay_pixel_shade.sv
